/* rtl/attm_pkg.sv */
// ----------------------------------------------------------------------------
// attm_pkg
// Shared widths, scale constants and control types for the attitude matrix
// core.
// ----------------------------------------------------------------------------
package attm_pkg;

  // fixed point format of the matrix entries
  localparam int FRAC_BITS = 14;

  // port widths
  localparam int IN_W  = 13;
  localparam int OUT_W = 16;

  // front end widths
  localparam int DOT_W = 27;              // dot product and raw cross product
  localparam int T_W   = 38;              // 1521 * dot
  localparam int MH_W  = 41;              // 10^8 * mag
  localparam int K_W   = 54;              // 10^8 * (mag x accel)
  localparam int H_W   = 52;              // orthogonalized mag, integer scaled

  // normalizer widths
  localparam int V_W   = 64;              // vector entry into the normalizer
  localparam int MAG_W = 63;              // magnitude of one entry
  localparam int NRM_W = 31;              // magnitude after range shift
  localparam int SQ_W  = 2 * NRM_W;       // square of one entry
  localparam int S_W   = 64;              // sum of squares
  localparam int GRP_W = 8;               // leading-one search group width
  localparam int NGRP  = V_W / GRP_W;
  localparam int GSEL_W = $clog2(GRP_W);
  localparam int MSB_W = $clog2(V_W);
  localparam int SH_W  = MSB_W;
  localparam int R_SHIFT = 2 * FRAC_BITS + 2;
  localparam int R_W   = SQ_W + R_SHIFT;  // 4 * m^2 * 2^(2*FRAC_BITS)
  localparam int ACC_W = 2 * FRAC_BITS + 70;
  localparam int Q_W   = FRAC_BITS + 1;   // unsigned quotient bits
  localparam int NSTEP = FRAC_BITS + 1;   // one stage per quotient bit

  // scale constants: 3.9 mg/count and 1/1000 folded into integers
  localparam int signed ACC_SQ    = 1521;
  localparam int signed MAG_SCALE = 100000000;

  // output saturation limits
  localparam int signed SAT_HI = (1 << (OUT_W - 1)) - 1;
  localparam int signed SAT_LO = -(1 << (OUT_W - 1));

  // pipeline depth
  localparam int FRONT_LAT = 4;
  localparam int NORM_LAT  = 6 + NSTEP;
  localparam int LAT       = FRONT_LAT + NORM_LAT + 1;

  typedef struct packed {
    logic valid;
    logic degen;
  } attm_ctl_t;

  typedef logic [2:0][V_W-1:0] attm_vec_t;
  typedef logic [2:0][Q_W:0]   attm_qvec_t;

endpackage

/* rtl/accel_mag_attitude_matrix_core.sv */
// ----------------------------------------------------------------------------
// accel_mag_attitude_matrix_core
// Attitude matrix from one accelerometer and one magnetometer sample.
// ----------------------------------------------------------------------------
// The core takes a new sample pair on every clock cycle at which start is
// high; busy never rises, since every beat moves one stage per cycle and the
// receiver cannot stall. The nine Q1.14 entries and the degenerate flag show
// up together with a one-cycle done pulse after the start beat has passed
// through four front-end stages, six range and sum-of-squares stages, one stage
// per quotient bit (FRAC_BITS + 1) in the unit-vector units, and the output
// register. When the cross product is zero, degenerate is set and the nine
// entries read zero.
module accel_mag_attitude_matrix_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_x,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_y,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_z,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_x,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_y,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_z,
  output logic                                done,
  output logic signed [attm_pkg::OUT_W-1:0]   north_x,
  output logic signed [attm_pkg::OUT_W-1:0]   north_y,
  output logic signed [attm_pkg::OUT_W-1:0]   north_z,
  output logic signed [attm_pkg::OUT_W-1:0]   east_x,
  output logic signed [attm_pkg::OUT_W-1:0]   east_y,
  output logic signed [attm_pkg::OUT_W-1:0]   east_z,
  output logic signed [attm_pkg::OUT_W-1:0]   down_x,
  output logic signed [attm_pkg::OUT_W-1:0]   down_y,
  output logic signed [attm_pkg::OUT_W-1:0]   down_z,
  output logic                                degenerate
);
  import attm_pkg::*;

  attm_ctl_t   fe_ctl;
  attm_ctl_t   nd_ctl;
  attm_vec_t   h_vec, k_vec, a_vec;
  attm_qvec_t  qn, qe, qd;

  // saturate one entry to the output width
  function automatic logic signed [OUT_W-1:0] sat(input logic signed [Q_W:0] x);
    logic signed [OUT_W-1:0] y;
    priority if (x > SAT_HI) begin
      y = OUT_W'(SAT_HI);
    end else if (x < SAT_LO) begin
      y = OUT_W'(SAT_LO);
    end else begin
      y = OUT_W'(x);
    end
    return y;
  endfunction

  assign busy = 1'b0;

  attm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .mag_x   (mag_x),
    .mag_y   (mag_y),
    .mag_z   (mag_z),
    .ctl     (fe_ctl),
    .h_vec   (h_vec),
    .k_vec   (k_vec),
    .a_vec   (a_vec)
  );

  attm_norm u_norm_n (
    .clk     (clk),
    .rst     (rst),
    .v       (h_vec),
    .ctl_in  (fe_ctl),
    .q       (qn),
    .ctl_out ()
  );

  attm_norm u_norm_e (
    .clk     (clk),
    .rst     (rst),
    .v       (k_vec),
    .ctl_in  (fe_ctl),
    .q       (qe),
    .ctl_out ()
  );

  attm_norm u_norm_d (
    .clk     (clk),
    .rst     (rst),
    .v       (a_vec),
    .ctl_in  (fe_ctl),
    .q       (qd),
    .ctl_out (nd_ctl)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= nd_ctl.valid;
    end
  end

  // result beat: zero the matrix on a degenerate sample
  always_ff @(posedge clk) begin
    degenerate <= nd_ctl.degen;
    if (nd_ctl.degen) begin
      north_x <= '0;
      north_y <= '0;
      north_z <= '0;
      east_x  <= '0;
      east_y  <= '0;
      east_z  <= '0;
      down_x  <= '0;
      down_y  <= '0;
      down_z  <= '0;
    end else begin
      north_x <= sat(qn[0]);
      north_y <= sat(qn[1]);
      north_z <= sat(qn[2]);
      east_x  <= sat(qe[0]);
      east_y  <= sat(qe[1]);
      east_z  <= sat(qe[2]);
      down_x  <= sat(qd[0]);
      down_y  <= sat(qd[1]);
      down_z  <= sat(qd[2]);
    end
  end

`ifndef SYNTHESIS
  // every result beat traces back to a start beat a fixed depth earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result beat without matching start beat");

  // degenerate beats carry an all-zero matrix
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (north_x == 0 && north_y == 0 && north_z == 0 &&
                              east_x == 0 && east_y == 0 && east_z == 0 &&
                              down_x == 0 && down_y == 0 && down_z == 0))
    else $error("degenerate beat with nonzero matrix");

  // a valid down column is a unit vector, so never all zero
  a_down_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (down_x != 0 || down_y != 0 || down_z != 0))
    else $error("down column is zero on a valid beat");
`endif

endmodule

/* rtl/attm_front.sv */
// ----------------------------------------------------------------------------
// attm_front
// Four-stage front end: products, scaling, and the orthogonalized magnetic
// vector, the cross product and the accel vector as integer vectors.
// ----------------------------------------------------------------------------
module attm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_x,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_y,
  input  logic signed [attm_pkg::IN_W-1:0]    accel_z,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_x,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_y,
  input  logic signed [attm_pkg::IN_W-1:0]    mag_z,
  output attm_pkg::attm_ctl_t                 ctl,
  output attm_pkg::attm_vec_t                 h_vec,
  output attm_pkg::attm_vec_t                 k_vec,
  output attm_pkg::attm_vec_t                 a_vec
);
  import attm_pkg::*;

  logic [FRONT_LAT-1:0]      vld;
  logic signed [IN_W-1:0]    a1 [3];
  logic signed [IN_W-1:0]    m1 [3];
  logic signed [IN_W-1:0]    a2 [3];
  logic signed [IN_W-1:0]    m2 [3];
  logic signed [DOT_W-1:0]   dot2;
  logic signed [DOT_W-1:0]   c2 [3];
  logic signed [IN_W-1:0]    a3 [3];
  logic signed [T_W-1:0]     t3;
  logic signed [MH_W-1:0]    mh3 [3];
  logic signed [K_W-1:0]     k3 [3];
  logic                      deg4;

  // valid bits travel with the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], start};
    end
  end

  // stage 1: capture samples
  always_ff @(posedge clk) begin
    a1[0] <= accel_x;
    a1[1] <= accel_y;
    a1[2] <= accel_z;
    m1[0] <= mag_x;
    m1[1] <= mag_y;
    m1[2] <= mag_z;
  end

  // stage 2: dot product and mag x accel
  always_ff @(posedge clk) begin
    dot2  <= DOT_W'(a1[0]) * DOT_W'(m1[0]) + DOT_W'(a1[1]) * DOT_W'(m1[1])
           + DOT_W'(a1[2]) * DOT_W'(m1[2]);
    c2[0] <= DOT_W'(m1[1]) * DOT_W'(a1[2]) - DOT_W'(m1[2]) * DOT_W'(a1[1]);
    c2[1] <= DOT_W'(m1[2]) * DOT_W'(a1[0]) - DOT_W'(m1[0]) * DOT_W'(a1[2]);
    c2[2] <= DOT_W'(m1[0]) * DOT_W'(a1[1]) - DOT_W'(m1[1]) * DOT_W'(a1[0]);
    a2    <= a1;
    m2    <= m1;
  end

  // stage 3: constant scaling
  always_ff @(posedge clk) begin
    t3 <= T_W'(dot2) * T_W'(ACC_SQ);
    for (int i = 0; i < 3; i++) begin
      k3[i]  <= K_W'(c2[i]) * K_W'(MAG_SCALE);
      mh3[i] <= MH_W'(m2[i]) * MH_W'(MAG_SCALE);
    end
    a3 <= a2;
  end

  // stage 4: remove the accel component; cross product of h and a is
  // 10^8 * (mag x accel) since the removed part is parallel to a
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h_vec[i] <= V_W'(H_W'(mh3[i]) - H_W'(t3) * H_W'(a3[i]));
      k_vec[i] <= V_W'(k3[i]);
      a_vec[i] <= V_W'(a3[i]);
    end
    deg4 <= (k3[0] == '0) && (k3[1] == '0) && (k3[2] == '0);
  end

  assign ctl = '{valid: vld[FRONT_LAT-1], degen: deg4};

endmodule

/* rtl/attm_norm.sv */
// ----------------------------------------------------------------------------
// attm_norm
// Pipelined unit vector: range shift, sum of squares, then one stage per
// quotient bit of round(m * 2^FRAC_BITS / sqrt(S)) with an exact test.
// ----------------------------------------------------------------------------
module attm_norm (
  input  logic                     clk,
  input  logic                     rst,
  input  attm_pkg::attm_vec_t      v,
  input  attm_pkg::attm_ctl_t      ctl_in,
  output attm_pkg::attm_qvec_t     q,
  output attm_pkg::attm_ctl_t      ctl_out
);
  import attm_pkg::*;

  attm_ctl_t                ctl1, ctl2, ctl3, ctl4, ctl5;
  logic [MAG_W-1:0]         mag_c [3];
  logic [MAG_W-1:0]         mag1 [3], mag2 [3], mag3 [3];
  logic [2:0]               sg1, sg2, sg3, sg4, sg5;
  logic [V_W-1:0]           orw;
  logic [NGRP-1:0]          gnz_c, gnz2;
  logic [GSEL_W-1:0]        gmsb_c [NGRP];
  logic [GSEL_W-1:0]        gmsb2 [NGRP];
  logic [MSB_W-1:0]         msb_c;
  logic [SH_W-1:0]          sh3;
  logic [NRM_W-1:0]         nm4 [3];
  logic [SQ_W-1:0]          sq5 [3];

  // per bit-stage state; index 0 is the seed
  attm_ctl_t                ctl_st [NSTEP+1];
  logic [S_W-1:0]           s_st   [NSTEP+1];
  logic [R_W-1:0]           rhs_st [NSTEP+1][3];
  logic signed [ACC_W-1:0]  p_st   [NSTEP+1][3];
  logic signed [ACC_W-1:0]  qa_st  [NSTEP+1][3];
  logic [Q_W-1:0]           r_st   [NSTEP+1][3];
  logic [2:0]               sg_st  [NSTEP+1];

  // control travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
      ctl_st[0] <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
      ctl_st[0] <= ctl5;
    end
  end

  // stage 1: magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v[i][V_W-1] ? MAG_W'(-$signed(v[i])) : MAG_W'(v[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] <= mag_c[i];
      sg1[i]  <= v[i][V_W-1];
    end
  end

  // stage 2: leading one per byte group
  always_comb begin
    orw = {1'b0, mag1[0] | mag1[1] | mag1[2]};
    for (int g = 0; g < NGRP; g++) begin
      gnz_c[g]  = |orw[g*GRP_W +: GRP_W];
      gmsb_c[g] = '0;
      for (int k = 0; k < GRP_W; k++) begin
        if (orw[g*GRP_W + k]) begin
          gmsb_c[g] = GSEL_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    gnz2  <= gnz_c;
    gmsb2 <= gmsb_c;
    mag2  <= mag1;
    sg2   <= sg1;
  end

  // stage 3: pick the top group, derive the range shift
  always_comb begin
    msb_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (gnz2[g]) begin
        msb_c = MSB_W'(g * GRP_W) + MSB_W'(gmsb2[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    sh3  <= (msb_c >= MSB_W'(NRM_W)) ? SH_W'(msb_c - MSB_W'(NRM_W - 1)) : '0;
    mag3 <= mag2;
    sg3  <= sg2;
  end

  // stage 4: bring every entry below 2^31
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nm4[i] <= NRM_W'(mag3[i] >> sh3);
    end
    sg4 <= sg3;
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq5[i] <= SQ_W'(nm4[i]) * SQ_W'(nm4[i]);
    end
    sg5 <= sg4;
  end

  // stage 6: sum of squares and seed of the bit search (r = 0)
  always_ff @(posedge clk) begin
    s_st[0]  <= S_W'(sq5[0]) + S_W'(sq5[1]) + S_W'(sq5[2]);
    sg_st[0] <= sg5;
    for (int i = 0; i < 3; i++) begin
      rhs_st[0][i] <= R_W'(sq5[i]) << R_SHIFT;
      p_st[0][i]   <= ACC_W'(S_W'(sq5[0]) + S_W'(sq5[1]) + S_W'(sq5[2]));
      qa_st[0][i]  <= -ACC_W'(S_W'(sq5[0]) + S_W'(sq5[1]) + S_W'(sq5[2]));
      r_st[0][i]   <= '0;
    end
  end

  // bit stages: P = (2r-1)^2 * S and QA = (2r-1) * S are kept so the
  // trial for each bit is shifts and adds only
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int B = FRAC_BITS - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_st[j+1] <= '0;
      end else begin
        ctl_st[j+1] <= ctl_st[j];
      end
    end

    always_ff @(posedge clk) begin
      s_st[j+1]  <= s_st[j];
      sg_st[j+1] <= sg_st[j];
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [ACC_W-1:0] s_ext;
      logic signed [ACC_W-1:0] rhs_ext;
      logic signed [ACC_W-1:0] trial;
      logic                    take;

      always_comb begin
        s_ext   = ACC_W'(s_st[j]);
        rhs_ext = ACC_W'(rhs_st[j][i]);
        trial   = p_st[j][i] + (qa_st[j][i] <<< (B + 2)) + (s_ext <<< (2 * B + 2));
        take    = (trial <= rhs_ext);
      end

      always_ff @(posedge clk) begin
        rhs_st[j+1][i] <= rhs_st[j][i];
        if (take) begin
          r_st[j+1][i]  <= r_st[j][i] | (Q_W'(1) << B);
          p_st[j+1][i]  <= trial;
          qa_st[j+1][i] <= qa_st[j][i] + (s_ext <<< (B + 1));
        end else begin
          r_st[j+1][i]  <= r_st[j][i];
          p_st[j+1][i]  <= p_st[j][i];
          qa_st[j+1][i] <= qa_st[j][i];
        end
      end
    end
  end

  // apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = sg_st[NSTEP][i] ? (Q_W+1)'(-$signed({1'b0, r_st[NSTEP][i]}))
                             : {1'b0, r_st[NSTEP][i]};
    end
  end

  assign ctl_out = ctl_st[NSTEP];

endmodule

/* tb/sv/tb_accel_mag_attitude_matrix_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_mag_attitude_matrix_core
// Drives sample pairs into the attitude matrix core and checks every matrix
// beat against an exact integer model of the orthogonalize, cross and
// normalize steps, kept in a small in-order scoreboard.
// ----------------------------------------------------------------------------
module tb_accel_mag_attitude_matrix_core;
  import attm_pkg::*;

  localparam int  N_RANDOM   = 1200;
  localparam int  CYCLE_CAP  = 200000;
  localparam int  QUIET_LO   = 400;
  localparam int  QUIET_HI   = 700;

  typedef logic signed [IN_W-1:0]  sample_t;
  typedef logic signed [OUT_W-1:0] entry_t;

  typedef struct {
    entry_t e[9];   // north x/y/z, east x/y/z, down x/y/z
    bit     degen;
  } matrix_t;

  // --------------------------------------------------------------------------
  // scoreboard: exact integer attitude matrix, in-order compare
  // --------------------------------------------------------------------------
  class attitude_scoreboard;
    matrix_t pending[$];
    int      errors;

    function automatic bit [63:0] absval(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic entry_t clamp16(longint v);
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      return entry_t'(v);
    endfunction

    // round(|v_i| * 2^FRAC_BITS / |v|), sign restored
    function automatic void normalize(input longint v[3], output longint q[3]);
      bit [63:0]  mg[3];
      bit [63:0]  sum;
      bit [127:0] lim, lhs;
      bit [63:0]  r, t, d;
      int         sh;
      sh  = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) mg[i] = absval(v[i]);
      while (((mg[0] >> sh) | (mg[1] >> sh) | (mg[2] >> sh)) >= (64'd1 << 31)) sh++;
      for (int i = 0; i < 3; i++) begin
        mg[i] = mg[i] >> sh;
        sum  += mg[i] * mg[i];
      end
      for (int i = 0; i < 3; i++) begin
        lim = 128'(mg[i] * mg[i]) << (2 * FRAC_BITS + 2);
        r   = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
          t   = r | (64'd1 << b);
          d   = 2 * t - 1;
          lhs = 128'(d * d) * 128'(sum);
          if (lhs <= lim) r = t;
        end
        q[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
      end
    endfunction

    // note one accepted sample pair
    function void note_sample(sample_t ax, sample_t ay, sample_t az,
                              sample_t mx, sample_t my, sample_t mz);
      longint  a[3], m[3], h[3], k[3], qn[3], qe[3], qd[3];
      longint  dot;
      matrix_t res;
      a[0] = ax; a[1] = ay; a[2] = az;
      m[0] = mx; m[1] = my; m[2] = mz;
      dot = a[0] * m[0] + a[1] * m[1] + a[2] * m[2];
      for (int i = 0; i < 3; i++) h[i] = MAG_SCALE * m[i] - ACC_SQ * dot * a[i];
      k[0] = h[1] * a[2] - h[2] * a[1];
      k[1] = h[2] * a[0] - h[0] * a[2];
      k[2] = h[0] * a[1] - h[1] * a[0];
      if (k[0] == 0 && k[1] == 0 && k[2] == 0) begin
        foreach (res.e[i]) res.e[i] = '0;
        res.degen = 1'b1;
      end else begin
        normalize(h, qn);
        normalize(k, qe);
        normalize(a, qd);
        for (int i = 0; i < 3; i++) begin
          res.e[i]     = clamp16(qn[i]);
          res.e[3 + i] = clamp16(qe[i]);
          res.e[6 + i] = clamp16(qd[i]);
        end
        res.degen = 1'b0;
      end
      pending.push_back(res);
    endfunction

    // compare one output beat with the oldest expected matrix
    function void check_matrix(matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix beat, nothing pending", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      foreach (want.e[i])
        if (got.e[i] !== want.e[i]) begin
          $display("%0t: entry %0d expected %0d actual %0d",
                   $time, i, want.e[i], got.e[i]);
          errors++;
        end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %0d actual %0d",
                 $time, want.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, DUT
  // --------------------------------------------------------------------------
  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  sample_t accel_x = '0, accel_y = '0, accel_z = '0;
  sample_t mag_x = '0, mag_y = '0, mag_z = '0;
  logic    busy, done, degenerate;
  entry_t  north_x, north_y, north_z, east_x, east_y, east_z;
  entry_t  down_x, down_y, down_z;

  attitude_scoreboard sb = new();
  int unsigned        cycles = 0;

  always #10 clk = ~clk;

  accel_mag_attitude_matrix_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
    .done(done),
    .north_x(north_x), .north_y(north_y), .north_z(north_z),
    .east_x(east_x), .east_y(east_y), .east_z(east_z),
    .down_x(down_x), .down_y(down_y), .down_z(down_z),
    .degenerate(degenerate)
  );

  // input beat monitor
  always @(posedge clk) begin
    if (!rst && start && !busy)
      sb.note_sample(accel_x, accel_y, accel_z, mag_x, mag_y, mag_z);
  end

  // output beat monitor
  always @(posedge clk) begin
    matrix_t got;
    if (!rst && done) begin
      got.e[0] = north_x; got.e[1] = north_y; got.e[2] = north_z;
      got.e[3] = east_x;  got.e[4] = east_y;  got.e[5] = east_z;
      got.e[6] = down_x;  got.e[7] = down_y;  got.e[8] = down_z;
      got.degen = degenerate;
      sb.check_matrix(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_pair(int ax, int ay, int az, int mx, int my, int mz);
    start   <= 1'b1;
    accel_x <= sample_t'(ax); accel_y <= sample_t'(ay); accel_z <= sample_t'(az);
    mag_x   <= sample_t'(mx); mag_y   <= sample_t'(my); mag_z   <= sample_t'(mz);
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic int rnd_count(bit narrow);
    if (narrow) return $urandom_range(0, 16) - 8;
    return $urandom_range(0, 8191) - 4096;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int  ax, ay, az, s;
    bit  narrow;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero accel, zero mag, parallel vectors, extremes, axes
    send_pair(0, 0, 0, 100, 200, 300);
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 256, 0, 0, 0);
    send_pair(0, 0, 256, 0, 0, 500);
    send_pair(10, 20, 30, 20, 40, 60);
    send_pair(-4096, -4096, -4096, -4096, -4096, -4096);
    send_pair(4095, 4095, 4095, 4095, 4095, 4095);
    send_pair(-4096, 4095, -4096, 4095, -4096, 4095);
    send_pair(4095, -4096, 4095, -4096, 4095, -4096);
    send_pair(256, 0, 0, 0, 300, 0);
    send_pair(0, 256, 0, 0, 0, 300);
    send_pair(0, 0, 256, 300, 0, 0);
    send_pair(0, 0, -256, 200, 50, -400);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(-1, -1, -1, 1, 1, 1);
    send_pair(1, 1, 0, 1, -1, 0);
    send_pair(12, -7, 250, 220, 5, -410);
    send_pair(4095, 0, 0, 0, 0, -4096);
    send_pair(3, 4, 0, 4, -3, 0);
    send_pair(-4096, 0, 1, 0, 4095, 0);

    // random: mostly full range, some small counts, some degenerate (parallel or zero mag)
    for (int n = 0; n < N_RANDOM; n++) begin
      narrow = ($urandom_range(0, 9) == 0);
      ax = rnd_count(narrow); ay = rnd_count(narrow); az = rnd_count(narrow);
      if ($urandom_range(0, 29) == 0) begin
        s = $urandom_range(0, 2) - 1;
        send_pair(ax, ay, az, s * ax, s * ay, s * az);
      end else
        send_pair(ax, ay, az, rnd_count(narrow), rnd_count(narrow), rnd_count(narrow));

      // hold off until the pipe has drained once
      if (n == 300) begin
        start <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      // idle gaps on about one beat in eight outside the quiet span: roughly 30% idle
      if ((n < QUIET_LO || n > QUIET_HI) && $urandom_range(0, 99) < 12)
        idle_cycles($urandom_range(1, 6));
    end
    start <= 1'b0;

    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (LAT + 10) @(posedge clk);

    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/attm_pkg.sv
rtl/attm_front.sv
rtl/attm_norm.sv
rtl/accel_mag_attitude_matrix_core.sv
tb/sv/tb_accel_mag_attitude_matrix_core.sv
